// File: design/serial_command_parser_top_assert.svh
// Assertion helpers used by the checker file of the command parser.
`ifndef SERIAL_COMMAND_PARSER_TOP_ASSERT_SVH
`define SERIAL_COMMAND_PARSER_TOP_ASSERT_SVH

// Condition that must hold in the same cycle as its trigger.
`define SCP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("serial_command_parser_top: same-cycle check failed");

// Condition that must hold in the cycle after its trigger.
`define SCP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("serial_command_parser_top: next-cycle check failed");

`endif

// File: design/scp_pkg.sv
`default_nettype none

package scp_pkg;

	// Characters of interest on the console.
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// Command letters.
	localparam logic [7:0] CMD_M    = 8'h6D;
	localparam logic [7:0] CMD_G    = 8'h67;
	localparam logic [7:0] CMD_A    = 8'h61;
	localparam logic [7:0] CMD_I    = 8'h69;
	localparam logic [7:0] CMD_NINE = 8'h39;
	localparam logic [7:0] CMD_P    = 8'h70;
	localparam logic [7:0] CMD_C    = 8'h63;
	localparam logic [7:0] CMD_R    = 8'h72;

	// Event codes reported on the result channel.
	localparam int EVENT_W = 4;
	typedef logic [EVENT_W-1:0] event_t;
	localparam event_t EV_NONE = 4'd0;
	localparam event_t EV_M    = 4'd1;
	localparam event_t EV_G    = 4'd2;
	localparam event_t EV_A    = 4'd3;
	localparam event_t EV_I    = 4'd4;
	localparam event_t EV_NINE = 4'd5;
	localparam event_t EV_P    = 4'd6;
	localparam event_t EV_C    = 4'd7;
	localparam event_t EV_R    = 4'd8;
	localparam event_t EV_LAST = EV_R;

	// Parameter field and its special values.
	localparam int PARAM_W = 10;
	typedef logic [PARAM_W-1:0] param_t;
	localparam param_t PARAM_LOW_MAX   = 10'd3;
	localparam param_t PARAM_M_SPECIAL = 10'd999;
	localparam param_t PARAM_A_SPECIAL = 10'd102;
	localparam param_t PARAM_MAX       = 10'd999;

endpackage

`default_nettype wire

// File: design/scp_rx_if.sv
`default_nettype none

// Channel carrying one received console byte per item.
interface scp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: design/scp_evt_if.sv
`default_nettype none

// Channel carrying one parser result per item.
interface scp_evt_if;
	logic            valid;
	logic            ready;
	scp_pkg::event_t event_code;
	scp_pkg::param_t cmd_param;
	logic            accepted;

	modport source (output valid, output event_code, output cmd_param, output accepted,
		input ready);
	modport sink (input valid, input event_code, input cmd_param, input accepted,
		output ready);
endinterface

`default_nettype wire

// File: design/serial_command_parser_top.sv
// Channel | Direction | Payload                               | Handshake
// rx      | in        | rx_byte[7:0]                          | valid/ready
// evt     | out       | event_code[3:0] cmd_param[9:0] accepted | valid/ready
//
// Every byte gives exactly one result item, one item per cycle sustained while evt is ready.
// An item waits in the input register until the result register is free or drained,
// then the character queue and the result register are updated together; the result
// is offered from the result register once the byte has passed both registers.
// Reset clears the character count and both valid flags; no clearing pass.
// A stalled result holds the output register; rx stays ready while the input
// register is empty or moving into the output register in the same cycle.

`default_nettype none

module serial_command_parser_top #(
	parameter int RING_SLOTS = 5
) (
	input wire logic   clk,
	input wire logic   arst_n,
	scp_rx_if.sink     rx,
	scp_evt_if.source  evt
);

	// The ring holds at most RING_SLOTS-1 characters; it is kept as a queue
	// with the oldest character at entry 0.
	localparam int DEPTH = RING_SLOTS - 1;
	localparam int CNT_W = $clog2(RING_SLOTS);
	localparam int XDEPTH = DEPTH + 4;

	logic [7:0]       chars_q [DEPTH];
	logic [CNT_W-1:0] count_q;

	logic [7:0] byte_s1;
	logic       valid_s1;

	logic            out_valid_q;
	scp_pkg::event_t event_q;
	scp_pkg::param_t param_q;
	logic            accepted_q;

	logic advance;

	// Input register advances when the result register is free or drained.
	assign advance  = valid_s1 && (!out_valid_q || evt.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (rx.valid && rx.ready) || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Queue contents padded with zeros so shifted reads stay in range.
	logic [7:0] chars_x [XDEPTH];

	always_comb begin
		for (int j = 0; j < DEPTH; j++) begin
			chars_x[j] = chars_q[j];
		end
		for (int j = DEPTH; j < XDEPTH; j++) begin
			chars_x[j] = 8'h00;
		end
	end

	// Line decode over the four oldest characters.
	logic [3:0] have;
	logic [3:1] is_digit;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			have[i] = count_q > CNT_W'(i);
		end
		for (int i = 1; i < 4; i++) begin
			is_digit[i] = (chars_x[i] >= scp_pkg::CHAR_ZERO) &&
				(chars_x[i] <= scp_pkg::CHAR_NINE);
		end
	end

	logic [2:0] pop_n;
	logic       line_ok;

	always_comb begin
		line_ok = 1'b0;
		priority if (!have[0]) begin
			pop_n = 3'd0;
		end else if (!have[1]) begin
			pop_n = 3'd1;
		end else if (!is_digit[1]) begin
			pop_n = 3'd2;
		end else if (!have[2]) begin
			pop_n = 3'd2;
		end else if (!is_digit[2]) begin
			pop_n = 3'd3;
		end else if (!have[3]) begin
			pop_n = 3'd3;
		end else if (!is_digit[3]) begin
			pop_n = 3'd4;
		end else begin
			pop_n = 3'd4;
			line_ok = 1'b1;
		end
	end

	// Three-digit parameter; the low nibble of an ASCII digit is its value.
	scp_pkg::param_t param;

	assign param = scp_pkg::PARAM_W'(chars_x[1][3:0]) * 10'd100 +
		scp_pkg::PARAM_W'(chars_x[2][3:0]) * 10'd10 +
		scp_pkg::PARAM_W'(chars_x[3][3:0]);

	// Command letter and its allowed parameters.
	scp_pkg::event_t cmd_event;
	logic            zero_p;
	logic            low_p;

	assign zero_p = param == '0;
	assign low_p  = param <= scp_pkg::PARAM_LOW_MAX;

	always_comb begin
		unique case (chars_x[0])
			scp_pkg::CMD_M: begin
				cmd_event = (low_p || param == scp_pkg::PARAM_M_SPECIAL) ?
					scp_pkg::EV_M : scp_pkg::EV_NONE;
			end
			scp_pkg::CMD_G:    cmd_event = zero_p ? scp_pkg::EV_G : scp_pkg::EV_NONE;
			scp_pkg::CMD_A: begin
				cmd_event = (low_p || param == scp_pkg::PARAM_A_SPECIAL) ?
					scp_pkg::EV_A : scp_pkg::EV_NONE;
			end
			scp_pkg::CMD_I:    cmd_event = zero_p ? scp_pkg::EV_I : scp_pkg::EV_NONE;
			scp_pkg::CMD_NINE: cmd_event = zero_p ? scp_pkg::EV_NINE : scp_pkg::EV_NONE;
			scp_pkg::CMD_P:    cmd_event = zero_p ? scp_pkg::EV_P : scp_pkg::EV_NONE;
			scp_pkg::CMD_C:    cmd_event = zero_p ? scp_pkg::EV_C : scp_pkg::EV_NONE;
			scp_pkg::CMD_R:    cmd_event = zero_p ? scp_pkg::EV_R : scp_pkg::EV_NONE;
			default:           cmd_event = scp_pkg::EV_NONE;
		endcase
	end

	// Next queue state for a pushed character or a consumed line.
	logic             is_cr;
	logic             full;
	logic [7:0]       chars_d [DEPTH];
	logic [CNT_W-1:0] count_d;
	scp_pkg::event_t  event_d;
	scp_pkg::param_t  param_d;
	logic             accepted_d;

	assign is_cr = byte_s1 == scp_pkg::CHAR_CR;
	assign full  = count_q == CNT_W'(DEPTH);

	always_comb begin
		event_d    = scp_pkg::EV_NONE;
		param_d    = '0;
		accepted_d = 1'b1;
		count_d    = count_q;
		for (int j = 0; j < DEPTH; j++) begin
			chars_d[j] = chars_q[j];
		end
		if (!is_cr) begin
			if (full) begin
				// Oldest character drops out.
				for (int j = 0; j < DEPTH; j++) begin
					chars_d[j] = (j == DEPTH - 1) ? byte_s1 : chars_x[j + 1];
				end
			end else begin
				for (int j = 0; j < DEPTH; j++) begin
					if (count_q == CNT_W'(j)) begin
						chars_d[j] = byte_s1;
					end
				end
				count_d = count_q + 1'b1;
			end
		end else begin
			for (int j = 0; j < DEPTH; j++) begin
				unique case (pop_n)
					3'd1:    chars_d[j] = chars_x[j + 1];
					3'd2:    chars_d[j] = chars_x[j + 2];
					3'd3:    chars_d[j] = chars_x[j + 3];
					3'd4:    chars_d[j] = chars_x[j + 4];
					default: chars_d[j] = chars_q[j];
				endcase
			end
			count_d = count_q - CNT_W'(pop_n);
			if (line_ok && cmd_event != scp_pkg::EV_NONE) begin
				event_d = cmd_event;
				param_d = param;
			end else begin
				accepted_d = 1'b0;
			end
		end
	end

	// Queue state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				count_q <= count_d;
			end
			out_valid_q <= advance || (out_valid_q && !evt.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int j = 0; j < DEPTH; j++) begin
				chars_q[j] <= chars_d[j];
			end
			event_q    <= event_d;
			param_q    <= param_d;
			accepted_q <= accepted_d;
		end
	end

	assign evt.valid      = out_valid_q;
	assign evt.event_code = event_q;
	assign evt.cmd_param  = param_q;
	assign evt.accepted   = accepted_q;

endmodule

`default_nettype wire

// File: design/scp_checker.sv
`default_nettype none

`include "serial_command_parser_top_assert.svh"

// Watches the result channel of the parser.
module scp_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            evt_valid,
	input wire logic            evt_ready,
	input wire scp_pkg::event_t event_code,
	input wire scp_pkg::param_t cmd_param,
	input wire logic            accepted
);

	// A stalled result stays offered and unchanged.
	`SCP_ASSERT_NEXT(a_hold_valid, evt_valid && !evt_ready, evt_valid)
	`SCP_ASSERT_NEXT(a_hold_payload, evt_valid && !evt_ready, $stable(event_code) && $stable(cmd_param) && $stable(accepted))

	// A rejected line carries no event and no parameter.
	`SCP_ASSERT_NOW(a_reject_clean, evt_valid && !accepted, event_code == scp_pkg::EV_NONE && cmd_param == '0)

	// An event is always an accepted command with a parameter in range.
	`SCP_ASSERT_NOW(a_event_sane, evt_valid && event_code != scp_pkg::EV_NONE, accepted && event_code <= scp_pkg::EV_LAST && cmd_param <= scp_pkg::PARAM_MAX)

endmodule

bind serial_command_parser_top scp_checker u_scp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.evt_valid  (evt.valid),
	.evt_ready  (evt.ready),
	.event_code (evt.event_code),
	.cmd_param  (evt.cmd_param),
	.accepted   (evt.accepted)
);

`default_nettype wire
